// ===== src/smhm_pkg.sv =====
// Shared types and constants for the short-name hash mangler.
package smhm_pkg;

   localparam int SMHM_QUEUE_DEPTH = 2;

   localparam logic [15:0] HASH_SEED       = 16'hBEEF;
   localparam logic [7:0]  CHAR_TILDE      = 8'h7E;
   localparam logic [7:0]  CHAR_DOT        = 8'h2E;
   localparam logic [7:0]  CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0]  CHAR_UPPER_A    = 8'h41;
   localparam logic [7:0]  CHAR_UPPER_Z    = 8'h5A;
   localparam logic [7:0]  CHAR_LOWER_A    = 8'h61;
   localparam logic [7:0]  CHAR_LOWER_Z    = 8'h7A;
   localparam logic [7:0]  CHAR_ZERO       = 8'h30;
   localparam logic [7:0]  CASE_OFFSET     = 8'h20;
   localparam logic [4:0]  LETTER_COUNT    = 5'd26;
   localparam logic [4:0]  SYMBOL_MASK     = 5'h1F;

   typedef struct packed {
      logic [3:0][7:0] prefix;
      logic [2:0]      prefix_len;
      logic [15:0]     hash;
      logic            has_ext;
      logic [1:0]      ext_count;
      logic [2:0][7:0] ext;
   } name_record_type;

endpackage

// ===== src/smhm_channels.sv =====
// Valid/ready channel interfaces for filename bytes and short-name characters.
interface smhm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] name_byte;
   logic       name_end;

   modport source (output valid, output name_byte, output name_end, input ready);
   modport sink   (input valid, input name_byte, input name_end, output ready);
endinterface

interface smhm_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_char;
   logic [15:0] hash_value;
   logic        out_last;

   modport source (output valid, output out_char, output hash_value, output out_last,
                   input ready);
   modport sink   (input valid, input out_char, input hash_value, input out_last,
                   output ready);
endinterface

// ===== src/smhm_front.sv =====
// Front end: hashes filename bytes and captures prefix and extension per name.
module smhm_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [7:0]                name_byte,
   input  logic                      name_end,
   input  logic                      queue_full,
   output logic                      push,
   output smhm_pkg::name_record_type push_record
);
   import smhm_pkg::*;

   function automatic logic [15:0] hash_low(input logic [7:0] b);
      logic [15:0] r;
      if (b[7]) begin
         r = {8'hFF, b};
      end else if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
         r = {8'h00, b + CASE_OFFSET};
      end else begin
         r = {8'h00, b};
      end
      return r;
   endfunction

   function automatic logic [15:0] hash_mix(input logic [15:0] h);
      return {h[12:0], 3'b000} ^ {5'b00000, h[15:5]};
   endfunction

   function automatic logic [7:0] map_char(input logic [7:0] b);
      logic [7:0] r;
      if (b[7] || b == 8'h00) begin
         r = CHAR_UNDERSCORE;
      end else begin
         case (b) inside
            "*", "?", "<", ">", "|", 8'h22, "+", "=", ",", ";", "[", "]", " ", "~", ".":
               r = CHAR_UNDERSCORE;
            default:
               r = (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z) ? b - CASE_OFFSET : b;
         endcase
      end
      return r;
   endfunction

   logic [15:0]     hash_ff, hash_in;
   logic [7:0]      prev_ff, prev_in;
   logic [2:0]      pos_ff, pos_in;
   logic [3:0][7:0] prefix_ff, prefix_in;
   logic [2:0]      pcount_ff, pcount_in;
   logic [2:0][7:0] ext_ff, ext_in;
   logic [1:0]      ecount_ff, ecount_in;
   logic            confirmed_ff, confirmed_in;
   logic            pending_ff, pending_in;
   logic [2:0]      dotpos_ff, dotpos_in;

   logic            accept;
   logic [15:0]     byte_low;
   logic [15:0]     step_hash;
   logic [15:0]     final_hash;
   logic [7:0]      mapped;
   logic [2:0]      plen;

   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;
   assign push     = accept && name_end;
   assign mapped   = map_char(name_byte);

   always_comb begin
      byte_low  = hash_low(name_byte);
      step_hash = hash_ff;
      if (pos_ff != 3'd0) begin
         step_hash = hash_mix(hash_ff) ^ hash_low(prev_ff) ^ {byte_low[7:0], 8'h00};
      end
      final_hash = hash_mix(step_hash) ^ byte_low;

      prefix_in = prefix_ff;
      pcount_in = pcount_ff;
      if (pos_ff < 3'd4) begin
         prefix_in[pos_ff[1:0]] = mapped;
         pcount_in = pos_ff + 3'd1;
      end

      confirmed_in = confirmed_ff;
      pending_in   = pending_ff;
      ecount_in    = ecount_ff;
      ext_in       = ext_ff;
      dotpos_in    = dotpos_ff;
      if (pending_ff) begin
         confirmed_in = 1'b1;
         pending_in   = 1'b0;
         ecount_in    = 2'd0;
      end
      if (confirmed_in && ecount_in < 2'd3) begin
         ext_in[ecount_in] = mapped;
         ecount_in = ecount_in + 2'd1;
      end
      if (name_byte == CHAR_DOT && pos_ff >= 3'd1 && !name_end) begin
         pending_in = 1'b1;
         dotpos_in  = (pos_ff > 3'd4) ? 3'd4 : pos_ff;
      end

      plen = pcount_in;
      if (confirmed_in && dotpos_in < plen) begin
         plen = dotpos_in;
      end

      push_record.prefix     = prefix_in;
      push_record.prefix_len = plen;
      push_record.hash       = final_hash;
      push_record.has_ext    = confirmed_in;
      push_record.ext_count  = ecount_in;
      push_record.ext        = ext_in;

      prev_in = name_byte;
      hash_in = step_hash;
      pos_in  = (pos_ff < 3'd5) ? pos_ff + 3'd1 : pos_ff;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         prefix_ff <= prefix_in;
         ext_ff    <= ext_in;
      end
      if (reset || push) begin
         hash_ff      <= HASH_SEED;
         prev_ff      <= 8'h00;
         pos_ff       <= 3'd0;
         pcount_ff    <= 3'd0;
         ecount_ff    <= 2'd0;
         confirmed_ff <= 1'b0;
         pending_ff   <= 1'b0;
         dotpos_ff    <= 3'd0;
      end else if (accept) begin
         hash_ff      <= hash_in;
         prev_ff      <= prev_in;
         pos_ff       <= pos_in;
         pcount_ff    <= pcount_in;
         ecount_ff    <= ecount_in;
         confirmed_ff <= confirmed_in;
         pending_ff   <= pending_in;
         dotpos_ff    <= dotpos_in;
      end
   end

endmodule

// ===== src/smhm_queue.sv =====
// Short register queue of finished name records between front and back.
module smhm_queue #(
   parameter int DEPTH = smhm_pkg::SMHM_QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  smhm_pkg::name_record_type push_record,
   output logic                      full,
   input  logic                      pop,
   output logic                      head_valid,
   output smhm_pkg::name_record_type head_record
);
   import smhm_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   name_record_type  entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full        = count_ff == CNT_W'(DEPTH);
   assign head_valid  = count_ff != '0;
   assign head_record = entry_ff[rd_ptr_ff];
   assign do_push     = push && !full;
   assign do_pop      = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_record;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== src/smhm_back.sv =====
// Back end: walks a name record and emits the 8.3 short name one character per beat.
module smhm_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      head_valid,
   input  smhm_pkg::name_record_type head_record,
   output logic                      pop,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [7:0]                out_char,
   output logic [15:0]               hash_value,
   output logic                      out_last
);
   import smhm_pkg::*;

   function automatic logic [7:0] symbol(input logic [4:0] v);
      logic [7:0] r;
      if (v < LETTER_COUNT) begin
         r = CHAR_UPPER_A + {3'b000, v};
      end else begin
         r = CHAR_ZERO + {3'b000, v - LETTER_COUNT};
      end
      return r;
   endfunction

   logic [3:0]  idx_ff, idx_in;
   logic        valid_ff, valid_in;
   logic [7:0]  char_ff, char_in;
   logic [15:0] hash_ff;
   logic        last_ff, last_in;
   logic        advance;
   logic [3:0]  total;
   logic [3:0]  ext_idx;

   assign advance = head_valid && (!valid_ff || out_ready);
   assign total   = head_record.has_ext ? 4'd9 + {2'b00, head_record.ext_count} : 4'd8;
   assign ext_idx = idx_ff - 4'd9;
   assign last_in = idx_ff == total - 4'd1;
   assign pop     = advance && last_in;

   always_comb begin
      if (idx_ff < {1'b0, head_record.prefix_len}) begin
         char_in = head_record.prefix[idx_ff[1:0]];
      end else if (idx_ff < 4'd5) begin
         char_in = CHAR_TILDE;
      end else if (idx_ff == 4'd5) begin
         char_in = symbol(head_record.hash[14:10] & SYMBOL_MASK);
      end else if (idx_ff == 4'd6) begin
         char_in = symbol(head_record.hash[9:5] & SYMBOL_MASK);
      end else if (idx_ff == 4'd7) begin
         char_in = symbol(head_record.hash[4:0] & SYMBOL_MASK);
      end else if (idx_ff == 4'd8) begin
         char_in = CHAR_DOT;
      end else begin
         char_in = head_record.ext[ext_idx[1:0]];
      end

      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (advance) begin
         idx_in   = last_in ? 4'd0 : idx_ff + 4'd1;
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         char_ff <= char_in;
         hash_ff <= head_record.hash;
         last_ff <= last_in;
      end
      if (reset) begin
         idx_ff   <= 4'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_char   = char_ff;
   assign hash_value = hash_ff;
   assign out_last   = last_ff;

endmodule

// ===== src/short_name_hash_mangler_unit.sv =====
// Top level of the short-name hash mangler: front end, record queue, back end.
//
//   channel    dir  payload                          beat
//   req_port   in   name_byte[8], name_end           one filename byte
//   rsp_port   out  out_char[8], hash_value[16],     one short-name character
//                   out_last
//
// The front end takes one filename byte per cycle; every byte waits while the
// record queue is full.
// The back end emits 8 to 12 characters per name, one per cycle while the output
// is ready, from the record at the queue head through a registered output stage.
// Reset is synchronous; there is no clearing pass.
// A stalled result holds the output register; the front keeps accepting bytes
// until the record queue fills.
module short_name_hash_mangler_unit #(
   parameter int QUEUE_DEPTH = smhm_pkg::SMHM_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   smhm_req_if.sink    req_port,
   smhm_rsp_if.source  rsp_port
);
   import smhm_pkg::*;

   logic            queue_full;
   logic            push;
   logic            pop;
   logic            head_valid;
   name_record_type push_record;
   name_record_type head_record;

   smhm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_port.valid),
      .in_ready    (req_port.ready),
      .name_byte   (req_port.name_byte),
      .name_end    (req_port.name_end),
      .queue_full  (queue_full),
      .push        (push),
      .push_record (push_record)
   );

   smhm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_record (push_record),
      .full        (queue_full),
      .pop         (pop),
      .head_valid  (head_valid),
      .head_record (head_record)
   );

   smhm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_record (head_record),
      .pop         (pop),
      .out_valid   (rsp_port.valid),
      .out_ready   (rsp_port.ready),
      .out_char    (rsp_port.out_char),
      .hash_value  (rsp_port.hash_value),
      .out_last    (rsp_port.out_last)
   );

endmodule
